/* rtl/core/hse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

  // one element of the set, ordered as signed two's complement
  typedef logic signed [31:0] word_t;

  // sequencer states: insert (sift up), sort (swap + sift down), emit
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_START,
    ST_UP_CMP,
    ST_UP_FIN,
    ST_RD_END,
    ST_RD_ROOT,
    ST_WR_END,
    ST_LEFT,
    ST_RIGHT,
    ST_DOWN_CMP,
    ST_DOWN_FIN,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/hse_heap_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module hse_heap_mem
  import hse_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire word_t            wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output word_t                 rdata_o
);

  word_t mem [Depth];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/heap_sort_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// heap sort engine: a run of signed 32-bit words is written in one word per start pulse,
// last_item_i closing the run. each word is pushed into a binary max-heap held in a
// single-port-read / single-port-write ram and sifted up at once; busy stays high while
// the word climbs, paced by the one ram read per heap level and the single shared signed
// comparator. on the closing word the engine swaps the root to the end and sifts down for
// each element, then streams the sorted run in ascending order, one word per cycle on
// consecutive cycles, each marked by strobe_o for exactly one cycle. there is no
// back-pressure: the receiver must take every word as it is shown. last_result_o marks the
// final word of a run; overflow_o is high on every word of a run in which words beyond
// MAX_ITEMS were dropped. a run of one word comes back as is. busy drops as the last word
// is read out, so a new run may start while that word is still on the outputs.
module heap_sort_engine_top
  import hse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  wire word_t value_i,
  input  wire logic  last_item_i,
  output logic       strobe_o,
  output word_t      sorted_value_o,
  output logic       last_result_o,
  output logic       overflow_o
);

  // ram address width and slot width (slots count 1..MAX_ITEMS, heap style)
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;      // words stored in this run
  logic          ovf_q, ovf_d;          // a word of this run was dropped
  logic          close_q, close_d;      // the word being inserted closes the run
  logic [CW-1:0] pos_q, pos_d;          // hole position, also emit slot
  logic [CW:0]   child_q, child_d;      // left child during sift down
  logic [CW-1:0] end_q, end_d;          // current heap end while sorting
  logic [CW-1:0] bpos_q, bpos_d;        // position of larger child
  word_t         best_q, best_d;        // value of larger child
  word_t         cur_q, cur_d;          // word being placed (sift up or down)

  logic strobe_q, strobe_d;
  logic last_res_q, last_res_d;
  logic ovf_out_q, ovf_out_d;

  // ram port
  logic          we, re;
  logic [CW-1:0] wslot, rslot;
  word_t         wdata, rdata;

  // shared compare unit
  word_t cmp_a, cmp_b;
  logic  cmp_lt;

  logic [CW-1:0] size;        // heap size during sift down
  logic [CW-1:0] up_par;      // parent of the hole during sift up
  logic [CW:0]   child_nx;    // left child of the larger child
  logic          room;
  state_e        close_tgt;

  assign size      = end_q - CW'(1);
  assign up_par    = pos_q >> 1;
  assign child_nx  = {bpos_q, 1'b0};
  assign room      = (count_q < CW'(MAX_ITEMS));
  assign close_tgt = (count_q > CW'(1)) ? ST_RD_END : ST_EMIT;

  assign cmp_lt = (cmp_a < cmp_b);

  hse_heap_mem #(
    .Depth (MAX_ITEMS),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(wslot - CW'(1))),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (AW'(rslot - CW'(1))),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (room) begin
            state_d = ST_UP_START;
          end else if (last_item_i) begin
            state_d = close_tgt;
          end
        end
      end
      ST_UP_START: begin
        state_d = (pos_q == CW'(1)) ? ST_UP_FIN : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (cmp_lt) begin
          state_d = (up_par == CW'(1)) ? ST_UP_FIN : ST_UP_CMP;
        end else begin
          state_d = close_q ? close_tgt : ST_IDLE;
        end
      end
      ST_UP_FIN:  state_d = close_q ? close_tgt : ST_IDLE;
      ST_RD_END:  state_d = ST_RD_ROOT;
      ST_RD_ROOT: state_d = ST_WR_END;
      ST_WR_END: begin
        state_d = (end_q >= CW'(3)) ? ST_LEFT : ST_DOWN_FIN;
      end
      ST_LEFT: begin
        state_d = (child_q < {1'b0, size}) ? ST_RIGHT : ST_DOWN_CMP;
      end
      ST_RIGHT: state_d = ST_DOWN_CMP;
      ST_DOWN_CMP: begin
        if (cmp_lt && (child_nx <= {1'b0, size})) begin
          state_d = ST_LEFT;
        end else begin
          state_d = ST_DOWN_FIN;
        end
      end
      ST_DOWN_FIN: begin
        state_d = (size > CW'(1)) ? ST_RD_END : ST_EMIT;
      end
      ST_EMIT: begin
        state_d = (pos_q == count_q) ? ST_IDLE : ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_d    = count_q;
    ovf_d      = ovf_q;
    close_d    = close_q;
    pos_d      = pos_q;
    child_d    = child_q;
    end_d      = end_q;
    bpos_d     = bpos_q;
    best_d     = best_q;
    cur_d      = cur_q;
    strobe_d   = 1'b0;
    last_res_d = 1'b0;
    ovf_out_d  = ovf_out_q;
    we         = 1'b0;
    re         = 1'b0;
    wslot      = pos_q;
    rslot      = pos_q;
    wdata      = cur_q;
    cmp_a      = cur_q;
    cmp_b      = best_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          close_d = last_item_i;
          end_d   = count_q;
          if (room) begin
            count_d = count_q + CW'(1);
            pos_d   = count_q + CW'(1);
            cur_d   = value_i;
          end else begin
            ovf_d = 1'b1;
            pos_d = CW'(1);
          end
        end
      end
      ST_UP_START: begin
        if (pos_q != CW'(1)) begin
          re    = 1'b1;
          rslot = up_par;
        end
      end
      ST_UP_CMP: begin
        // parent smaller than the new word: move parent down into the hole
        cmp_a = rdata;
        cmp_b = cur_q;
        we    = 1'b1;
        if (cmp_lt) begin
          wdata = rdata;
          pos_d = up_par;
          if (up_par != CW'(1)) begin
            re    = 1'b1;
            rslot = up_par >> 1;
          end
        end else begin
          end_d = count_q;
          pos_d = CW'(1);
        end
      end
      ST_UP_FIN: begin
        we    = 1'b1;
        end_d = count_q;
        pos_d = CW'(1);
      end
      ST_RD_END: begin
        re    = 1'b1;
        rslot = end_q;
      end
      ST_RD_ROOT: begin
        re    = 1'b1;
        rslot = CW'(1);
        cur_d = rdata;
      end
      ST_WR_END: begin
        // old root goes to the end, hole opens at the root
        we      = 1'b1;
        wslot   = end_q;
        wdata   = rdata;
        pos_d   = CW'(1);
        child_d = (CW + 1)'(2);
        if (end_q >= CW'(3)) begin
          re    = 1'b1;
          rslot = CW'(2);
        end
      end
      ST_LEFT: begin
        best_d = rdata;
        bpos_d = child_q[CW-1:0];
        if (child_q < {1'b0, size}) begin
          re    = 1'b1;
          rslot = CW'(child_q + (CW + 1)'(1));
        end
      end
      ST_RIGHT: begin
        cmp_a = best_q;
        cmp_b = rdata;
        if (cmp_lt) begin
          best_d = rdata;
          bpos_d = bpos_q + CW'(1);
        end
      end
      ST_DOWN_CMP: begin
        // placed word smaller than larger child: child moves up
        cmp_a = cur_q;
        cmp_b = best_q;
        if (cmp_lt) begin
          we      = 1'b1;
          wdata   = best_q;
          pos_d   = bpos_q;
          child_d = child_nx;
          if (child_nx <= {1'b0, size}) begin
            re    = 1'b1;
            rslot = child_nx[CW-1:0];
          end
        end
      end
      ST_DOWN_FIN: begin
        we    = 1'b1;
        end_d = size;
        pos_d = CW'(1);
      end
      ST_EMIT: begin
        re         = 1'b1;
        strobe_d   = 1'b1;
        last_res_d = (pos_q == count_q);
        ovf_out_d  = ovf_q;
        pos_d      = pos_q + CW'(1);
        if (pos_q == count_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      close_q    <= 1'b0;
      strobe_q   <= 1'b0;
      last_res_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      close_q    <= close_d;
      strobe_q   <= strobe_d;
      last_res_q <= last_res_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    child_q   <= child_d;
    end_q     <= end_d;
    bpos_q    <= bpos_d;
    best_q    <= best_d;
    cur_q     <= cur_d;
    ovf_out_q <= ovf_out_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign strobe_o       = strobe_q;
  assign sorted_value_o = rdata;
  assign last_result_o  = last_res_q;
  assign overflow_o     = ovf_out_q;

endmodule

`default_nettype wire

/* rtl/core/heap_sort_engine_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_engine_checker
  import hse_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  start,
  input wire logic  busy,
  input wire word_t value_i,
  input wire logic  last_item_i,
  input wire logic  strobe_o,
  input wire word_t sorted_value_o,
  input wire logic  last_result_o,
  input wire logic  overflow_o
);

  // last marker only rides on a shown word
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> strobe_o)
    else $error("last_result without strobe");

  // a run streams out on consecutive cycles
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_result_o) |=> strobe_o)
    else $error("gap inside result burst");

  // the final word is not directly followed by another shown word
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_result_o) |=> !strobe_o)
    else $error("word after last_result");

  // overflow flag is the same on every word of a run
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_result_o) |=> (overflow_o == $past(overflow_o)))
    else $error("overflow changed within a run");

  // an accepted word never produces a result on the next cycle
  a_no_strobe_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !strobe_o)
    else $error("strobe right after accept");

endmodule

bind heap_sort_engine_top heap_sort_engine_checker u_checker (.*);

`default_nettype wire
